// ===== rtl/ikcf_pkg.sv =====
package ikcf_pkg;

    localparam int CHAIN_LENGTH = 8;
    localparam int IDX_W        = (CHAIN_LENGTH > 1) ? $clog2(CHAIN_LENGTH) : 1;
    localparam int COORD_W      = 24;
    localparam int SEG_W        = 16;
    localparam int NODE_W       = 6;
    localparam int RAD_W        = 61;   // (ax^2 + ay^2) << 12
    localparam int ROOT_W       = 31;
    localparam int NUM_W        = 48;
    localparam int DEN_W        = 32;
    localparam int SUM_W        = NUM_W + 2;

    localparam logic [SEG_W-1:0] SEG_RESET = 16'd4096;
    localparam logic signed [COORD_W-1:0] COORD_MAX = 24'sh7FFFFF;
    localparam logic signed [COORD_W-1:0] COORD_MIN = -24'sh800000;

    typedef struct packed {
        logic signed [COORD_W-1:0] target_x;
        logic signed [COORD_W-1:0] target_y;
    } in_t;

    typedef struct packed {
        logic [NODE_W-1:0]         node_index;
        logic signed [COORD_W-1:0] node_x;
        logic signed [COORD_W-1:0] node_y;
        logic                      last_node;
    } out_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } joint_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PUT,
        ST_READ,
        ST_DIFF,
        ST_SQUARE,
        ST_SQ_START,
        ST_SQ_WAIT,
        ST_MUL_X,
        ST_DIV_X_START,
        ST_DIV_X_WAIT,
        ST_MUL_Y,
        ST_DIV_Y_START,
        ST_DIV_Y_WAIT,
        ST_FINISH
    } state_t;

endpackage

// ===== rtl/ikcf_joint_ram.sv =====
module ikcf_joint_ram (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  we,
    input  logic [ikcf_pkg::IDX_W-1:0] waddr,
    input  ikcf_pkg::joint_t      wdata,
    input  logic                  re,
    input  logic [ikcf_pkg::IDX_W-1:0] raddr,
    output ikcf_pkg::joint_t      rdata
);
    import ikcf_pkg::*;

    joint_t                  mem [CHAIN_LENGTH];
    logic [CHAIN_LENGTH-1:0] valid_reg;
    joint_t                  data_reg;
    logic                    hit_reg;

    // Entries never written since reset read as the origin.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            if (re)
            begin
                hit_reg <= valid_reg[raddr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            data_reg <= mem[raddr];
        end
    end

    assign rdata = hit_reg ? data_reg : '0;

endmodule

// ===== rtl/ikcf_sqrt.sv =====
module ikcf_sqrt (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [ikcf_pkg::RAD_W-1:0]   radicand,
    output logic                         done,
    output logic [ikcf_pkg::ROOT_W-1:0]  root
);
    import ikcf_pkg::*;

    localparam logic [4:0] K_TOP = 5'd30;

    logic [RAD_W-1:0] n_reg;
    logic [RAD_W-1:0] res_reg;
    logic [4:0]       k_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [RAD_W-1:0] bit_w;
    logic [RAD_W-1:0] trial;

    // One result bit per cycle, scanning bit pairs from the top.
    assign bit_w = RAD_W'(1) << {k_reg, 1'b0};
    assign trial = res_reg + bit_w;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            k_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                k_reg    <= K_TOP;
            end
            else if (busy_reg)
            begin
                if (k_reg == 5'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    k_reg <= k_reg - 5'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg   <= radicand;
            res_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (n_reg >= trial)
            begin
                n_reg   <= n_reg - trial;
                res_reg <= (res_reg >> 1) + bit_w;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
        end
    end

    assign done = done_reg;
    assign root = res_reg[ROOT_W-1:0];

endmodule

// ===== rtl/ikcf_div.sv =====
module ikcf_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [ikcf_pkg::NUM_W-1:0]  num,
    input  logic [ikcf_pkg::DEN_W-1:0]  den,
    output logic                        done,
    output logic [ikcf_pkg::NUM_W-1:0]  quot
);
    import ikcf_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] q_reg;
    logic [DEN_W:0]   rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   diff;

    // Restoring division, one quotient bit per cycle.
    assign shifted = {rem_reg[DEN_W-1:0], q_reg[NUM_W-1]};
    assign diff    = shifted - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            if (!diff[DEN_W])
            begin
                rem_reg <= diff;
                q_reg   <= {q_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted;
                q_reg   <= {q_reg[NUM_W-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

// ===== rtl/ik_chain_follow_pass.sv =====
// Channel   | Handshake              | Payload
// ----------+------------------------+-----------------------------------------
// input     | in_valid / in_ready    | in_data  : target_x, target_y
// output    | out_valid / out_ready  | out_data : node_index, node_x, node_y,
//           |                        |            last_node
// config    | cfg_we (no wait)       | cfg_wdata: segment_length
//
// One target transaction yields CHAIN_LENGTH result transactions. Joint 0 is
// loaded into the output register from PUT once that register is free. Every
// later joint passes through READ, DIFF, SQUARE, the 31-step square root,
// MUL_X and a 48-step divide, then MUL_Y and a second 48-step divide that
// shares one iterative divider with the first, and FINISH; a joint that
// coincides with its predecessor goes from DIFF straight back to PUT.
// Reset clears the joint memory through per-entry valid bits, so the block is
// ready in the first cycle after reset. The sequencer waits in place while
// the output register holds an untaken transaction.
module ik_chain_follow_pass (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  ikcf_pkg::in_t                  in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output ikcf_pkg::out_t                 out_data,
    input  logic                           cfg_we,
    input  logic [ikcf_pkg::SEG_W-1:0]     cfg_wdata
);
    import ikcf_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CHAIN_LENGTH - 1);

    state_t state_reg;
    state_t state_next;

    logic [SEG_W-1:0] seg_len_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             out_valid_reg;
    out_t             out_reg;

    // Datapath registers; cur holds the joint being finished, prev the joint
    // it follows.
    joint_t              cur_reg;
    joint_t              prev_reg;
    logic [COORD_W-1:0]  ax_reg;
    logic [COORD_W-1:0]  ay_reg;
    logic                sx_reg;
    logic                sy_reg;
    logic [2*COORD_W-1:0] ax2_reg;
    logic [2*COORD_W-1:0] ay2_reg;
    logic [ROOT_W-1:0]   s_reg;
    logic [COORD_W+SEG_W-1:0] prod_reg;
    logic [NUM_W-1:0]    qx_reg;

    // Control decoded from the state.
    logic mem_we;
    logic mem_re;
    logic sq_start;
    logic div_start;
    logic out_load;
    logic out_free;

    joint_t           mem_wdata;
    logic [IDX_W-1:0] mem_waddr;
    joint_t           mem_rdata;

    logic [RAD_W-1:0] radicand;
    logic             sq_done;
    logic [ROOT_W-1:0] sq_root;
    logic [NUM_W-1:0] div_num;
    logic             div_done;
    logic [NUM_W-1:0] div_quot;

    logic signed [COORD_W:0] dx;
    logic signed [COORD_W:0] dy;
    logic [COORD_W:0]        dx_abs;
    logic [COORD_W:0]        dy_abs;
    logic signed [COORD_W-1:0] new_x;
    logic signed [COORD_W-1:0] new_y;

    function automatic logic signed [COORD_W-1:0] step_sat(
        input logic signed [COORD_W-1:0] base,
        input logic [NUM_W-1:0]          mag,
        input logic                      neg
    );
        logic signed [SUM_W-1:0] off;
        logic signed [SUM_W-1:0] sum;
        off = neg ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
        sum = SUM_W'(base) + off;
        if (sum > SUM_W'(COORD_MAX))
        begin
            return COORD_MAX;
        end
        else if (sum < SUM_W'(COORD_MIN))
        begin
            return COORD_MIN;
        end
        return sum[COORD_W-1:0];
    endfunction

    assign out_free = !out_valid_reg || out_ready;

    // Differences between the stored old joint and the updated predecessor.
    assign dx     = $signed({mem_rdata.x[COORD_W-1], mem_rdata.x})
                  - $signed({prev_reg.x[COORD_W-1], prev_reg.x});
    assign dy     = $signed({mem_rdata.y[COORD_W-1], mem_rdata.y})
                  - $signed({prev_reg.y[COORD_W-1], prev_reg.y});
    assign dx_abs = dx[COORD_W] ? 25'(-dx) : 25'(dx);
    assign dy_abs = dy[COORD_W] ? 25'(-dy) : 25'(dy);

    assign radicand = RAD_W'({1'b0, ax2_reg} + {1'b0, ay2_reg}) << 12;
    assign div_num  = NUM_W'({prod_reg, 7'b0}) + NUM_W'(s_reg);

    assign new_x = step_sat(prev_reg.x, qx_reg, sx_reg);
    assign new_y = step_sat(prev_reg.y, div_quot, sy_reg);

    always_comb
    begin
        if (state_reg == ST_IDLE)
        begin
            mem_waddr = '0;
            mem_wdata = '{x: in_data.target_x, y: in_data.target_y};
        end
        else
        begin
            mem_waddr = idx_reg;
            mem_wdata = '{x: new_x, y: new_y};
        end
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_PUT;
                end
            end
            ST_PUT:
            begin
                if (out_free)
                begin
                    state_next = (idx_reg == LAST_IDX) ? ST_IDLE : ST_READ;
                end
            end
            ST_READ:     state_next = ST_DIFF;
            ST_DIFF:
            begin
                // Coincident points: the joint lands on its predecessor.
                state_next = (dx == '0 && dy == '0) ? ST_PUT : ST_SQUARE;
            end
            ST_SQUARE:   state_next = ST_SQ_START;
            ST_SQ_START: state_next = ST_SQ_WAIT;
            ST_SQ_WAIT:
            begin
                if (sq_done)
                begin
                    state_next = ST_MUL_X;
                end
            end
            ST_MUL_X:       state_next = ST_DIV_X_START;
            ST_DIV_X_START: state_next = ST_DIV_X_WAIT;
            ST_DIV_X_WAIT:
            begin
                if (div_done)
                begin
                    state_next = ST_MUL_Y;
                end
            end
            ST_MUL_Y:       state_next = ST_DIV_Y_START;
            ST_DIV_Y_START: state_next = ST_DIV_Y_WAIT;
            ST_DIV_Y_WAIT:
            begin
                if (div_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:   state_next = ST_PUT;
            default:     state_next = ST_IDLE;
        endcase
    end

    // Output decode.
    always_comb
    begin
        in_ready  = 1'b0;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        sq_start  = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                mem_we   = in_valid;
            end
            ST_PUT:         out_load  = out_free;
            ST_READ:        mem_re    = 1'b1;
            ST_SQ_START:    sq_start  = 1'b1;
            ST_DIV_X_START: div_start = 1'b1;
            ST_DIV_Y_START: div_start = 1'b1;
            ST_FINISH:      mem_we    = 1'b1;
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            seg_len_reg   <= SEG_RESET;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                seg_len_reg <= cfg_wdata;
            end
            if (state_reg == ST_IDLE)
            begin
                idx_reg <= '0;
            end
            else if (out_load && idx_reg != LAST_IDX)
            begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                cur_reg <= '{x: in_data.target_x, y: in_data.target_y};
            end
            ST_PUT:
            begin
                if (out_free)
                begin
                    prev_reg <= cur_reg;
                    out_reg  <= '{node_index: NODE_W'(idx_reg),
                                  node_x:     cur_reg.x,
                                  node_y:     cur_reg.y,
                                  last_node:  (idx_reg == LAST_IDX)};
                end
            end
            ST_DIFF:
            begin
                ax_reg  <= dx_abs[COORD_W-1:0];
                ay_reg  <= dy_abs[COORD_W-1:0];
                sx_reg  <= dx[COORD_W];
                sy_reg  <= dy[COORD_W];
                if (dx == '0 && dy == '0)
                begin
                    // Store the collapsed joint before it is emitted.
                    cur_reg <= prev_reg;
                end
            end
            ST_SQUARE:
            begin
                ax2_reg <= ax_reg * ax_reg;
                ay2_reg <= ay_reg * ay_reg;
            end
            ST_SQ_WAIT:
            begin
                if (sq_done)
                begin
                    s_reg <= sq_root;
                end
            end
            ST_MUL_X:       prod_reg <= ax_reg * seg_len_reg;
            ST_DIV_X_WAIT:
            begin
                if (div_done)
                begin
                    qx_reg <= div_quot;
                end
            end
            ST_MUL_Y:       prod_reg <= ay_reg * seg_len_reg;
            ST_FINISH:      cur_reg  <= '{x: new_x, y: new_y};
            default:
            begin
            end
        endcase
    end

    // The collapsed joint must also reach memory; the write in DIFF covers it.
    logic mem_we_all;
    joint_t mem_wdata_all;
    assign mem_we_all    = mem_we || (state_reg == ST_DIFF && dx == '0 && dy == '0);
    assign mem_wdata_all = (state_reg == ST_DIFF) ? prev_reg : mem_wdata;

    ikcf_joint_ram u_ram (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (mem_we_all),
        .waddr (mem_waddr),
        .wdata (mem_wdata_all),
        .re    (mem_re),
        .raddr (idx_reg),
        .rdata (mem_rdata)
    );

    ikcf_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (radicand),
        .done     (sq_done),
        .root     (sq_root)
    );

    ikcf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   ({s_reg, 1'b0}),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule
